// ----- sv/ds2i_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package ds2i_pkg;

	localparam int MAX_LEN_DEF = 65535;
	localparam int PosW        = 16;
	localparam int AccW        = 64;
	localparam int CountW      = 5;
	localparam int PhaseW      = 3;

	localparam logic [CountW-1:0] MAX_DIGITS = 5'd20;

	localparam logic [PhaseW-1:0] PH_WS     = 3'd0;
	localparam logic [PhaseW-1:0] PH_SIGN   = 3'd1;
	localparam logic [PhaseW-1:0] PH_DIGITS = 3'd2;
	localparam logic [PhaseW-1:0] PH_DONE   = 3'd3;
	localparam logic [PhaseW-1:0] PH_NONE   = 3'd4;

	localparam logic [1:0] ST_POS  = 2'd0;
	localparam logic [1:0] ST_NEG  = 2'd1;
	localparam logic [1:0] ST_NONE = 2'd2;
	localparam logic [1:0] ST_OVF  = 2'd3;

	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_MINUS = 8'h2d;
	localparam logic [7:0] CH_PLUS  = 8'h2b;
	localparam logic [7:0] CH_0     = 8'h30;
	localparam logic [7:0] CH_9     = 8'h39;

	localparam logic [AccW-1:0] POS_LIMIT_DIV10 = 64'd1844674407370955161;
	localparam logic [AccW-1:0] NEG_LIMIT       = 64'h8000_0000_0000_0000;
	localparam logic [3:0]      LAST_DIGIT_MAX  = 4'd5;

	typedef struct packed {
		logic [PhaseW-1:0] phase;
		logic              is_negative;
		logic [AccW-1:0]   accumulator;
		logic [CountW-1:0] digit_count;
		logic              overflowed;
		logic [PosW-1:0]   position;
		logic [PosW-1:0]   end_position;
	} state_t;

	typedef struct packed {
		logic            done;
		logic            is_negative;
		logic            overflowed;
		logic [AccW-1:0] accumulator;
		logic [PosW-1:0] end_position;
	} fin_t;

	localparam state_t STATE_RST = '0;

endpackage

`default_nettype wire

// ----- sv/ds2i_step.sv -----
`timescale 1ns / 1ps
`default_nettype none

module ds2i_step
	import ds2i_pkg::*;
#(
	parameter int MAX_LEN = MAX_LEN_DEF
) (
	input  wire state_t     st,
	input  wire logic [7:0] char_code,
	input  wire logic       is_last,
	output state_t          st_next,
	output fin_t            fin
);

	state_t nx;
	logic is_digit;
	logic take_digit;
	logic [3:0] d;

	always_comb begin
		nx = st;
		take_digit = 1'b0;
		is_digit = char_code inside {[CH_0:CH_9]};
		d = 4'(char_code - CH_0);
		if (st.position < PosW'(MAX_LEN)) begin
			nx.position = st.position + PosW'(1);
			case (st.phase)
				PH_WS: begin
					if (char_code == CH_SPACE || char_code == CH_TAB) begin
						nx.phase = PH_WS;
					end else if (char_code == CH_MINUS) begin
						nx.is_negative = 1'b1;
						nx.phase = PH_SIGN;
					end else if (char_code == CH_PLUS) begin
						nx.phase = PH_SIGN;
					end else if (is_digit) begin
						nx.phase = PH_DIGITS;
						take_digit = 1'b1;
					end else begin
						nx.phase = PH_NONE;
					end
				end
				PH_SIGN: begin
					if (is_digit) begin
						nx.phase = PH_DIGITS;
						take_digit = 1'b1;
					end else begin
						nx.phase = PH_NONE;
					end
				end
				PH_DIGITS: begin
					take_digit = 1'b1;
				end
				default: begin
					take_digit = 1'b0;
				end
			endcase
			if (take_digit) begin
				if (!is_digit) begin
					nx.end_position = st.position;
					nx.phase = PH_DONE;
				end else if (st.digit_count == '0 && d == 4'd0) begin
					// leading zero
					nx.digit_count = st.digit_count;
				end else if (st.digit_count >= MAX_DIGITS) begin
					nx.overflowed = 1'b1;
					nx.end_position = st.position;
					nx.phase = PH_DONE;
				end else begin
					if (st.accumulator > POS_LIMIT_DIV10 ||
						(st.accumulator == POS_LIMIT_DIV10 && d > LAST_DIGIT_MAX)) begin
						nx.overflowed = 1'b1;
					end else begin
						// times ten as two shifts and an add
						nx.accumulator = {st.accumulator[AccW-4:0], 3'b000}
							+ {st.accumulator[AccW-2:0], 1'b0} + AccW'(d);
					end
					nx.digit_count = st.digit_count + CountW'(1);
				end
			end
		end

		fin.done = (nx.phase == PH_DONE) || (nx.phase == PH_DIGITS);
		fin.is_negative = nx.is_negative;
		fin.overflowed = nx.overflowed;
		fin.accumulator = nx.accumulator;
		fin.end_position = (nx.phase == PH_DIGITS) ? nx.position : nx.end_position;

		st_next = is_last ? STATE_RST : nx;
	end

endmodule

`default_nettype wire

// ----- sv/decimal_string_to_int64_unit.sv -----
// decimal string to 64-bit integer converter
// input channel: one string byte per item (char_code) with is_last on the
// final byte; in_valid / in_ready handshake
// output channel: one result per string (value, status, stop_offset) with
// out_valid / out_ready handshake; bytes without is_last give no result
// status: ok positive, ok negative, no number, overflow
// throughput: one byte per cycle while in_ready is high; strings may follow
// each other directly; a string's result passes the input register, the
// finished-string register and the result register before out_valid
// the per-byte loop is one multiply-by-ten add and a limit compare on the
// running magnitude; sign handling and negation run one stage later
// when out_ready is low the result is held and one more finished string
// waits in the middle stage; after that in_ready drops only for a last byte
// reset clears all valid flags and the conversion state, so the first byte
// after reset starts a new string
// MAX_LEN bounds the bytes examined per string; later ones are ignored
`timescale 1ns / 1ps
`default_nettype none

module decimal_string_to_int64_unit
	import ds2i_pkg::*;
#(
	parameter int MAX_LEN = MAX_LEN_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [7:0]  char_code,
	input  wire logic        is_last,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [63:0]      value,
	output logic [1:0]       status,
	output logic [15:0]      stop_offset
);

	logic       valid_s1;
	logic [7:0] char_s1;
	logic       last_s1;
	state_t     st_q;
	state_t     st_next;
	fin_t       fin;
	logic       valid_s2;
	fin_t       fin_s2;
	logic       out_valid_q;
	logic [AccW-1:0] value_q;
	logic [1:0]      status_q;
	logic [PosW-1:0] offset_q;

	logic out_free;
	logic s2_free;
	logic s1_fire;
	logic [AccW-1:0] value_d;
	logic [1:0]      status_d;
	logic [PosW-1:0] offset_d;

	ds2i_step #(
		.MAX_LEN(MAX_LEN)
	) u_step (
		.st        (st_q),
		.char_code (char_s1),
		.is_last   (last_s1),
		.st_next   (st_next),
		.fin       (fin)
	);

	assign out_free = !out_valid_q || out_ready;
	assign s2_free  = !valid_s2 || out_free;
	assign s1_fire  = valid_s1 && (!last_s1 || s2_free);
	assign in_ready = !valid_s1 || s1_fire;

	always_comb begin
		value_d = '0;
		status_d = ST_NONE;
		offset_d = '0;
		if (fin_s2.done) begin
			offset_d = fin_s2.end_position;
			if (fin_s2.overflowed || (fin_s2.is_negative && fin_s2.accumulator > NEG_LIMIT)) begin
				value_d = fin_s2.is_negative ? NEG_LIMIT : '1;
				status_d = ST_OVF;
			end else if (fin_s2.is_negative) begin
				value_d = '0 - fin_s2.accumulator;
				status_d = ST_NEG;
			end else begin
				value_d = fin_s2.accumulator;
				status_d = ST_POS;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			out_valid_q <= 1'b0;
			st_q <= STATE_RST;
		end else begin
			if (in_ready) begin
				valid_s1 <= in_valid;
			end
			if (s1_fire) begin
				st_q <= st_next;
			end
			if (s1_fire && last_s1) begin
				valid_s2 <= 1'b1;
			end else if (out_free) begin
				valid_s2 <= 1'b0;
			end
			if (valid_s2 && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			char_s1 <= char_code;
			last_s1 <= is_last;
		end
		if (s1_fire && last_s1) begin
			fin_s2 <= fin;
		end
		if (valid_s2 && out_free) begin
			value_q <= value_d;
			status_q <= status_d;
			offset_q <= offset_d;
		end
	end

	assign out_valid   = out_valid_q;
	assign value       = value_q;
	assign status      = status_q;
	assign stop_offset = offset_q;

`ifndef SYNTH
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		st_q.digit_count <= MAX_DIGITS)
		else $error("digit count past limit");

	a_ws_clean: assert property (@(posedge clk) disable iff (!arst_n)
		st_q.phase == PH_WS |-> (st_q.accumulator == '0 && st_q.digit_count == '0))
		else $error("magnitude nonzero before any digit");

	a_clear_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		(s1_fire && last_s1) |=> (st_q.position == '0 && st_q.phase == PH_WS))
		else $error("state not cleared after last item");

	a_s2_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && out_valid_q && !out_ready) |=> (valid_s2 && $stable(fin_s2)))
		else $error("pending result lost under stall");
`endif

endmodule

`default_nettype wire

// ----- tb/tb_decimal_string_to_int64_unit.sv -----
`timescale 1ns / 1ps

import ds2i_pkg::*;

typedef struct packed {
	logic [63:0] value;
	logic [1:0]  status;
	logic [15:0] offset;
} conv_result_t;

class int64_parse_scoreboard;
	logic [PhaseW-1:0] phase;
	bit                neg;
	logic [AccW-1:0]   mag;
	logic [CountW-1:0] ndig;
	bit                ovf;
	int unsigned       pos;
	logic [PosW-1:0]   stop_pos;
	conv_result_t      expected_q[$];
	int unsigned       errors;
	int unsigned       status_seen[4];

	function new();
		errors = 0;
		foreach (status_seen[i]) status_seen[i] = 0;
		clear();
	endfunction

	function void clear();
		phase = PH_WS;
		neg = 1'b0;
		mag = '0;
		ndig = '0;
		ovf = 1'b0;
		pos = 0;
		stop_pos = '0;
	endfunction

	function int pending();
		return expected_q.size();
	endfunction

	function void take_digit(logic [7:0] ch, int unsigned p);
		logic [3:0] d;
		if (ch < CH_0 || ch > CH_9) begin
			stop_pos = PosW'(p);
			phase = PH_DONE;
			return;
		end
		d = 4'(ch - CH_0);
		if (ndig == 0 && d == 0)
			return;
		if (ndig >= MAX_DIGITS) begin
			ovf = 1'b1;
			stop_pos = PosW'(p);
			phase = PH_DONE;
			return;
		end
		if (mag > POS_LIMIT_DIV10 || (mag == POS_LIMIT_DIV10 && d > LAST_DIGIT_MAX))
			ovf = 1'b1;
		else
			mag = mag * 64'd10 + 64'(d);
		ndig++;
	endfunction

	function void note_char(logic [7:0] ch, logic lst);
		conv_result_t r;
		int unsigned  p;
		if (pos < MAX_LEN_DEF) begin
			p = pos;
			pos++;
			case (phase)
				PH_WS: begin
					if (ch == CH_SPACE || ch == CH_TAB) begin
					end else if (ch == CH_MINUS) begin
						neg = 1'b1;
						phase = PH_SIGN;
					end else if (ch == CH_PLUS) begin
						phase = PH_SIGN;
					end else if (ch >= CH_0 && ch <= CH_9) begin
						phase = PH_DIGITS;
						take_digit(ch, p);
					end else begin
						phase = PH_NONE;
					end
				end
				PH_SIGN: begin
					if (ch >= CH_0 && ch <= CH_9) begin
						phase = PH_DIGITS;
						take_digit(ch, p);
					end else begin
						phase = PH_NONE;
					end
				end
				PH_DIGITS: take_digit(ch, p);
				default: ;
			endcase
		end
		if (!lst)
			return;
		if (phase == PH_DIGITS) begin
			stop_pos = PosW'(pos);
			phase = PH_DONE;
		end
		if (phase != PH_DONE) begin
			r.value = '0;
			r.status = ST_NONE;
			r.offset = '0;
		end else begin
			r.offset = stop_pos;
			if (ovf || (neg && mag > NEG_LIMIT)) begin
				r.value = neg ? NEG_LIMIT : '1;
				r.status = ST_OVF;
			end else if (neg) begin
				r.value = 64'd0 - mag;
				r.status = ST_NEG;
			end else begin
				r.value = mag;
				r.status = ST_POS;
			end
		end
		expected_q.push_back(r);
		clear();
	endfunction

	function void check_result(logic [63:0] v, logic [1:0] s, logic [15:0] o);
		conv_result_t r;
		if (expected_q.size() == 0) begin
			errors++;
			$display("%0t: unexpected result, expected none, got value %h status %0d offset %0d",
				$time, v, s, o);
			return;
		end
		r = expected_q.pop_front();
		status_seen[r.status]++;
		if (v !== r.value) begin
			errors++;
			$display("%0t: value mismatch, expected %h, got %h", $time, r.value, v);
		end
		if (s !== r.status) begin
			errors++;
			$display("%0t: status mismatch, expected %0d, got %0d", $time, r.status, s);
		end
		if (o !== r.offset) begin
			errors++;
			$display("%0t: stop_offset mismatch, expected %0d, got %0d", $time, r.offset, o);
		end
	endfunction
endclass

module tb_decimal_string_to_int64_unit;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic [7:0]  char_code = 8'h00;
	logic        is_last = 1'b0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [63:0] value;
	logic [1:0]  status;
	logic [15:0] stop_offset;

	int64_parse_scoreboard sb;
	logic [7:0]            text_q[$];
	int unsigned           idle_pct = 0;
	int unsigned           stall_pct = 0;
	int unsigned           bytes_sent = 0;
	int unsigned           phase_start;

	decimal_string_to_int64_unit u_top (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.char_code  (char_code),
		.is_last    (is_last),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.value      (value),
		.status     (status),
		.stop_offset(stop_offset)
	);

	always #10 clk = ~clk;

	always @(posedge clk) begin
		if (out_valid && out_ready)
			sb.check_result(value, status, stop_offset);
		out_ready <= ($urandom_range(99) >= stall_pct);
	end

	task automatic send_item(input logic [7:0] ch, input logic lst);
		if ($urandom_range(99) < idle_pct) begin
			in_valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < idle_pct);
		end
		in_valid <= 1'b1;
		char_code <= ch;
		is_last <= lst;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		sb.note_char(ch, lst);
		bytes_sent++;
	endtask

	task automatic send_text();
		foreach (text_q[i]) send_item(text_q[i], i == text_q.size() - 1);
	endtask

	function automatic void add_str(string s);
		for (int i = 0; i < s.len(); i++) text_q.push_back(s[i]);
	endfunction

	function automatic void add_digits(int unsigned n);
		repeat (n) text_q.push_back(8'(CH_0 + $urandom_range(9)));
	endfunction

	task automatic send_str(string s);
		text_q.delete();
		add_str(s);
		send_text();
	endtask

	task automatic wait_results();
		in_valid <= 1'b0;
		do @(posedge clk); while (sb.pending() != 0);
	endtask

	// mostly well-formed numbers, some broken after the sign, some pure noise
	function automatic void make_random_text();
		int unsigned kind;
		int unsigned sgn;
		kind = $urandom_range(99);
		text_q.delete();
		if (kind < 15) begin
			repeat ($urandom_range(1, 6)) text_q.push_back(8'($urandom_range(255)));
			return;
		end
		repeat ($urandom_range(0, 3)) text_q.push_back($urandom_range(1) ? CH_SPACE : CH_TAB);
		sgn = $urandom_range(3);
		if (sgn == 0)
			text_q.push_back(CH_MINUS);
		else if (sgn == 1)
			text_q.push_back(CH_PLUS);
		if (kind < 25) begin
			if ($urandom_range(1))
				text_q.push_back(8'($urandom_range(255)));
			if (text_q.size() == 0)
				text_q.push_back(CH_PLUS);
			return;
		end
		if ($urandom_range(3) == 0)
			repeat ($urandom_range(1, 3)) text_q.push_back(CH_0);
		case ($urandom_range(9))
			0, 1: begin
				if (sgn == 0)
					add_str("922337203685477580");
				else
					add_str("1844674407370955161");
				add_digits($urandom_range(1, 2));
			end
			2: add_digits($urandom_range(19, 23));
			default: add_digits($urandom_range(1, 18));
		endcase
		case ($urandom_range(3))
			0: repeat ($urandom_range(1, 3)) text_q.push_back(8'($urandom_range(255)));
			1: text_q.push_back(CH_SPACE);
			default: ;
		endcase
	endfunction

	initial begin
		#(2_000_000);
		$display("status: fail");
		$finish;
	end

	initial begin
		sb = new();
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_str("0");
		send_str("-00");
		send_str(" \t+123x9");
		send_str("-");
		send_str(" \t ");
		send_str("+-5");
		send_str("a12");
		send_str(" 42 7");
		text_q.delete();
		text_q.push_back(8'hff);
		send_text();
		text_q.delete();
		text_q.push_back(8'h00);
		send_text();
		send_str("18446744073709551615");
		send_str("18446744073709551616");
		send_str("-9223372036854775808");
		send_str("-9223372036854775809");
		send_str("000123456789012345678901");
		wait_results();

		for (int ph = 0; ph < 4; ph++) begin
			case (ph)
				0: begin idle_pct = 0; stall_pct = 0; end
				1: begin idle_pct = 75; stall_pct = 0; end
				2: begin idle_pct = 0; stall_pct = 75; end
				default: begin idle_pct = 34; stall_pct = 34; end
			endcase
			phase_start = bytes_sent;
			while (bytes_sent - phase_start < 150) begin
				make_random_text();
				send_text();
			end
			wait_results();
		end

		stall_pct = 0;
		repeat (10) @(posedge clk);
		$display("run covered %0d bytes: directed edge strings, then four handshake mixes",
			bytes_sent);
		$display("results: %0d positive, %0d negative, %0d no number, %0d overflow",
			sb.status_seen[ST_POS], sb.status_seen[ST_NEG], sb.status_seen[ST_NONE],
			sb.status_seen[ST_OVF]);
		if (sb.errors == 0 && sb.pending() == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule
